// File: src/dtab_pkg.sv
// shared types and constants for the depth tested alpha blend writer
package dtab_pkg;

	localparam int unsigned DEF_PIXEL_COUNT = 65536;
	localparam int unsigned DEF_DEPTH_BITS  = 16;
	localparam int unsigned IDX_IN_W        = 16;
	localparam int unsigned CHAN_W          = 8;
	// fixed point shift of the index reciprocal
	localparam int unsigned RECIP_SHIFT     = 32;

	typedef struct packed {
		logic [IDX_IN_W-1:0] pixel_index;
		logic [15:0]         depth;
		logic [CHAN_W-1:0]   src_red;
		logic [CHAN_W-1:0]   src_green;
		logic [CHAN_W-1:0]   src_blue;
		logic [CHAN_W-1:0]   src_alpha;
	} frag_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
		logic [CHAN_W-1:0] out_alpha;
		logic              depth_passed;
	} result_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_SUB,
		ST_READ,
		ST_BLEND1,
		ST_BLEND2,
		ST_WRITE
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic clr_wr;
		logic load;
		logic mul1;
		logic mul2;
		logic sub;
		logic rd;
		logic blend1;
		logic blend2;
		logic wr;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic clr_last;
		logic out_free;
	} dp_sts_t;

endpackage

// File: src/dtab_ctrl.sv
// controller state machine of the depth tested alpha blend writer
module dtab_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              frag_valid,
	output logic              frag_stall,
	input  dtab_pkg::dp_sts_t sts,
	output dtab_pkg::dp_cmd_t cmd
);
	import dtab_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (frag_valid) begin
					state_nxt = ST_MUL1;
				end
			end
			ST_MUL1:   state_nxt = ST_MUL2;
			ST_MUL2:   state_nxt = ST_SUB;
			ST_SUB:    state_nxt = ST_READ;
			ST_READ:   state_nxt = ST_BLEND1;
			ST_BLEND1: state_nxt = ST_BLEND2;
			ST_BLEND2: state_nxt = ST_WRITE;
			ST_WRITE: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default:   state_nxt = ST_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		cmd        = '0;
		frag_stall = 1'b1;
		case (state_q)
			ST_CLEAR:  cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				frag_stall = 1'b0;
				cmd.load   = frag_valid;
			end
			ST_MUL1:   cmd.mul1   = 1'b1;
			ST_MUL2:   cmd.mul2   = 1'b1;
			ST_SUB:    cmd.sub    = 1'b1;
			ST_READ:   cmd.rd     = 1'b1;
			ST_BLEND1: cmd.blend1 = 1'b1;
			ST_BLEND2: cmd.blend2 = 1'b1;
			ST_WRITE:  cmd.wr     = sts.out_free;
			default:   cmd        = '0;
		endcase
	end

endmodule

// File: src/dtab_dp.sv
// datapath of the depth tested alpha blend writer: index reduction, stores, blend lanes
module dtab_dp #(
	parameter int unsigned PIXEL_COUNT = dtab_pkg::DEF_PIXEL_COUNT,
	parameter int unsigned DEPTH_BITS  = dtab_pkg::DEF_DEPTH_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dtab_pkg::frag_t   frag,
	input  dtab_pkg::dp_cmd_t cmd,
	output dtab_pkg::dp_sts_t sts,
	output logic              result_valid,
	input  logic              result_stall,
	output dtab_pkg::result_t result
);
	import dtab_pkg::*;

	localparam int unsigned IDX_W = $clog2(PIXEL_COUNT);
	localparam int unsigned REM_W = IDX_IN_W + 1;
	localparam int unsigned PROD_W = IDX_IN_W + RECIP_SHIFT;
	// ceil(2^32 / PIXEL_COUNT): exact quotient for any 16 bit index
	localparam logic [63:0] RECIP64 =
		((64'd1 << RECIP_SHIFT) + 64'(PIXEL_COUNT) - 64'd1) / 64'(PIXEL_COUNT);
	localparam logic [RECIP_SHIFT-1:0] RECIP = RECIP_SHIFT'(RECIP64);
	localparam logic [REM_W-1:0] PC_REM =
		(PIXEL_COUNT > ((1 << REM_W) - 1)) ? {REM_W{1'b1}} : REM_W'(PIXEL_COUNT);

	// one blend: ((s+1)*w + (d+1)*(256-w)) >> 8 as 256*(d+1) + w*(s-d), saturated
	function automatic logic [CHAN_W-1:0] blend(input logic [CHAN_W-1:0] s,
		input logic [CHAN_W-1:0] d, input logic [CHAN_W-1:0] w);
		logic signed [9:0]  diff;
		logic signed [18:0] sum;
		logic [10:0]        v;
		diff = $signed({2'b00, s}) - $signed({2'b00, d});
		sum  = $signed({2'b00, ({1'b0, d} + 9'd1), 8'h00}) + diff * $signed({2'b00, w});
		v    = sum[18:8];
		return (v > 11'd255) ? {CHAN_W{1'b1}} : v[CHAN_W-1:0];
	endfunction

	logic [DEPTH_BITS-1:0] depth_mem [PIXEL_COUNT];
	logic [31:0]           colour_mem [PIXEL_COUNT];

	logic [IDX_W-1:0]      clr_addr_q;
	frag_t                 frag_q;
	logic [DEPTH_BITS-1:0] z_q;
	logic [PROD_W-1:0]     prod_q;
	logic [REM_W-1:0]      qn_q;
	logic [IDX_W-1:0]      idx_q;
	logic [DEPTH_BITS-1:0] rd_depth_q;
	logic [31:0]           rd_colour_q;
	logic                  pass_q;
	logic [CHAN_W-1:0]     old_a_q;
	logic [CHAN_W-1:0]     dst_q [3];
	logic [CHAN_W-1:0]     t_q [3];
	logic [CHAN_W-1:0]     res_q [3];
	logic                  out_valid_q;
	result_t               out_q;

	logic [CHAN_W-1:0]     src [3];
	logic [REM_W-1:0]      rem;
	logic [REM_W-1:0]      rem_fix;
	logic                  mem_we;
	logic                  depth_we;
	logic [IDX_W-1:0]      mem_addr;
	logic [DEPTH_BITS-1:0] depth_wdata;
	logic [31:0]           colour_wdata;

	assign src[0] = frag_q.src_red;
	assign src[1] = frag_q.src_green;
	assign src[2] = frag_q.src_blue;

	// status
	assign sts.clr_last = (clr_addr_q == IDX_W'(PIXEL_COUNT - 1));
	assign sts.out_free = !out_valid_q || !result_stall;

	// clear sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_wr && !sts.clr_last) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// fragment capture and index reduction modulo pixel count
	assign rem     = {1'b0, frag_q.pixel_index} - qn_q;
	assign rem_fix = (rem >= PC_REM) ? (rem - PC_REM) : rem;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			frag_q <= frag;
			z_q    <= DEPTH_BITS'(frag.depth);
		end
		if (cmd.mul1) begin
			prod_q <= PROD_W'(frag_q.pixel_index) * PROD_W'(RECIP);
		end
		if (cmd.mul2) begin
			qn_q <= REM_W'(32'(prod_q[PROD_W-1:RECIP_SHIFT]) * 32'(PIXEL_COUNT));
		end
		if (cmd.sub) begin
			idx_q <= IDX_W'(rem_fix);
		end
	end

	// store write port, shared by the clear sweep and the fragment write
	assign mem_we       = cmd.clr_wr || cmd.wr;
	assign depth_we     = cmd.clr_wr || (cmd.wr && pass_q);
	assign mem_addr     = cmd.clr_wr ? clr_addr_q : idx_q;
	assign depth_wdata  = cmd.clr_wr ? '0 : z_q;
	assign colour_wdata = cmd.clr_wr ? '0 :
		{frag_q.src_alpha, res_q[2], res_q[1], res_q[0]};

	always_ff @(posedge clk) begin
		if (depth_we) begin
			depth_mem[mem_addr] <= depth_wdata;
		end
		if (mem_we) begin
			colour_mem[mem_addr] <= colour_wdata;
		end
	end

	// registered store read
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_depth_q  <= depth_mem[idx_q];
			rd_colour_q <= colour_mem[idx_q];
		end
	end

	// blend lanes, one per color channel
	always_ff @(posedge clk) begin
		if (cmd.blend1) begin
			pass_q  <= (z_q >= rd_depth_q);
			old_a_q <= rd_colour_q[31:24];
		end
		for (int c = 0; c < 3; c++) begin
			if (cmd.blend1) begin
				dst_q[c] <= rd_colour_q[8*c +: 8];
				t_q[c]   <= blend(src[c], rd_colour_q[8*c +: 8], frag_q.src_alpha);
			end
			if (cmd.blend2) begin
				res_q[c] <= pass_q ? t_q[c] : blend(t_q[c], dst_q[c], old_a_q);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.wr) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			out_q.out_red      <= res_q[0];
			out_q.out_green    <= res_q[1];
			out_q.out_blue     <= res_q[2];
			out_q.out_alpha    <= frag_q.src_alpha;
			out_q.depth_passed <= pass_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// File: src/depth_tested_alpha_blend_writer.sv
// top level of the depth tested alpha blend writer
//
// channel   direction  handshake                  payload
// frag      in         frag_valid / frag_stall    dtab_pkg::frag_t
// result    out        result_valid / result_stall dtab_pkg::result_t
//
// one fragment in work at a time: accept, two multiplies and a subtract to reduce
// the index, a registered store read, two blend steps and the store write.
// the store write waits while the output register holds an untaken result;
// the next fragment is accepted while that result is still waiting.
// after reset a clearing pass zeroes both stores, with frag_stall held high.
module depth_tested_alpha_blend_writer #(
	parameter int unsigned PIXEL_COUNT = dtab_pkg::DEF_PIXEL_COUNT,
	parameter int unsigned DEPTH_BITS  = dtab_pkg::DEF_DEPTH_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              frag_valid,
	output logic              frag_stall,
	input  dtab_pkg::frag_t   frag,
	output logic              result_valid,
	input  logic              result_stall,
	output dtab_pkg::result_t result
);
	import dtab_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// controller
	dtab_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.frag_valid (frag_valid),
		.frag_stall (frag_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// datapath
	dtab_dp #(
		.PIXEL_COUNT (PIXEL_COUNT),
		.DEPTH_BITS  (DEPTH_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.frag         (frag),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// File: src/dtab_chk.sv
// port checker for the depth tested alpha blend writer, with its bind
module dtab_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              frag_valid,
	input logic              frag_stall,
	input dtab_pkg::frag_t   frag,
	input logic              result_valid,
	input logic              result_stall,
	input dtab_pkg::result_t result
);
	import dtab_pkg::*;

	logic       frag_xfer;
	logic       result_xfer;
	logic [1:0] pending_q;

	assign frag_xfer   = frag_valid && !frag_stall;
	assign result_xfer = result_valid && !result_stall;

	// fragments taken minus results delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (frag_xfer && !result_xfer) begin
			pending_q <= pending_q + 1'b1;
		end else if (result_xfer && !frag_xfer) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// a stalled fragment holds
	a_frag_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frag_valid && frag_stall |=> frag_valid && $stable(frag))
		else $error("stalled fragment changed");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// one fragment in work at a time
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		frag_xfer |=> frag_stall)
		else $error("fragment accepted while one is in work");

	// no result without a fragment behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != 2'd0)
		else $error("result without a pending fragment");

	// at most one in work and one waiting at the output
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("too many fragments outstanding");

endmodule

bind depth_tested_alpha_blend_writer dtab_chk u_dtab_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.frag_valid   (frag_valid),
	.frag_stall   (frag_stall),
	.frag         (frag),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// File: tb/sv/tb_depth_tested_alpha_blend_writer.sv
// self-checking testbench for the depth tested alpha blend writer
`timescale 1ns / 1ps

module tb_depth_tested_alpha_blend_writer;
	import dtab_pkg::*;

	localparam int unsigned PIX          = DEF_PIXEL_COUNT;
	localparam int unsigned RANDOM_FRAGS = 1150;
	// run limit lies well above the clearing pass plus the slowest fragment stream
	localparam int unsigned RUN_LIMIT    = 1000000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned MAX_WAIT     = 14;

	logic    clk;
	logic    arst_n       = 1'b0;
	logic    frag_valid   = 1'b0;
	logic    frag_stall;
	frag_t   frag         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// shadow copies of the depth and colour stores
	logic [15:0] depth_mem  [PIX];
	logic [31:0] colour_mem [PIX];
	result_t     pending_writes [$];

	int unsigned error_count = 0;
	int unsigned frags_sent  = 0;
	int unsigned results_seen = 0;
	int unsigned depth_wins  = 0;
	int unsigned depth_losses = 0;
	int unsigned cycle_count = 0;
	int unsigned stall_left  = 0;
	bit          quiet       = 1'b0;

	depth_tested_alpha_blend_writer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.frag_valid   (frag_valid),
		.frag_stall   (frag_stall),
		.frag         (frag),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("depth_tested_alpha_blend_writer regression: fail");
			$finish;
		end
	end

	function automatic int unsigned draw_wait();
		return quiet ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	// one weighted channel mix, clamped at full scale
	function automatic logic [7:0] mix_channel(input logic [7:0] src, input logic [7:0] dst,
			input logic [7:0] w);
		int unsigned sum;
		sum = (32'(src) + 1) * 32'(w) + (32'(dst) + 1) * (256 - 32'(w));
		sum = sum >> 8;
		return (sum > 255) ? 8'hff : sum[7:0];
	endfunction

	// depth test, blend and store update for one fragment
	function automatic result_t blend_and_store(input frag_t f);
		result_t     r;
		logic [31:0] old;
		logic [7:0]  old_a;
		logic [7:0]  s [3];
		logic [7:0]  ch [3];
		logic [7:0]  t;
		logic [7:0]  d;
		logic        passed;
		old    = colour_mem[f.pixel_index];
		old_a  = old[31:24];
		s      = '{f.src_red, f.src_green, f.src_blue};
		passed = f.depth >= depth_mem[f.pixel_index];
		if (passed)
			depth_mem[f.pixel_index] = f.depth;
		for (int c = 0; c < 3; c++) begin
			d     = old[8*c +: 8];
			t     = mix_channel(s[c], d, f.src_alpha);
			ch[c] = passed ? t : mix_channel(t, d, old_a);
		end
		colour_mem[f.pixel_index] = {f.src_alpha, ch[2], ch[1], ch[0]};
		if (passed)
			depth_wins++;
		else
			depth_losses++;
		r.out_red      = ch[0];
		r.out_green    = ch[1];
		r.out_blue     = ch[2];
		r.out_alpha    = f.src_alpha;
		r.depth_passed = passed;
		return r;
	endfunction

	function automatic frag_t make_frag(input logic [15:0] pix, input logic [15:0] z,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b, input logic [7:0] a);
		frag_t f;
		f.pixel_index = pix;
		f.depth       = z;
		f.src_red     = r;
		f.src_green   = g;
		f.src_blue    = b;
		f.src_alpha   = a;
		return f;
	endfunction

	// compare one result transfer against the oldest prediction
	task automatic check_result(input result_t got);
		result_t want;
		results_seen++;
		if (pending_writes.size() == 0) begin
			$error("result transfer with no fragment pending: %p", got);
			error_count++;
		end else begin
			want = pending_writes.pop_front();
			if (got.out_red !== want.out_red) begin
				$error("out_red expected %0d actual %0d", want.out_red, got.out_red);
				error_count++;
			end
			if (got.out_green !== want.out_green) begin
				$error("out_green expected %0d actual %0d", want.out_green, got.out_green);
				error_count++;
			end
			if (got.out_blue !== want.out_blue) begin
				$error("out_blue expected %0d actual %0d", want.out_blue, got.out_blue);
				error_count++;
			end
			if (got.out_alpha !== want.out_alpha) begin
				$error("out_alpha expected %0d actual %0d", want.out_alpha, got.out_alpha);
				error_count++;
			end
			if (got.depth_passed !== want.depth_passed) begin
				$error("depth_passed expected %0d actual %0d", want.depth_passed,
					got.depth_passed);
				error_count++;
			end
		end
	endtask

	// result side: random back-pressure between transfers
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			check_result(result);
			stall_left = draw_wait();
		end else if (stall_left > 0) begin
			stall_left--;
		end
		result_stall <= (stall_left > 0);
	end

	// fragment side: optional gap, then hold until the transfer
	task automatic send_fragment(input frag_t f);
		int unsigned gap;
		gap = draw_wait();
		if (gap > 0) begin
			frag_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frag_valid <= 1'b1;
		frag       <= f;
		do @(posedge clk); while (frag_stall !== 1'b0);
		pending_writes.push_back(blend_and_store(f));
		frags_sent++;
	endtask

	// cleared stores: equal depth at zero passes, zero alpha still blends
	task automatic test_cleared_stores;
		send_fragment(make_frag(16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00));
		send_fragment(make_frag(16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff));
		send_fragment(make_frag(16'h5555, 16'haaaa, 8'haa, 8'h55, 8'haa, 8'h55));
		send_fragment(make_frag(16'haaaa, 16'h5555, 8'h55, 8'haa, 8'h55, 8'haa));
	endtask

	// sums that reach 256 must clamp, also when fed to the second mix
	task automatic test_saturation;
		send_fragment(make_frag(16'h0100, 16'h8000, 8'hff, 8'hff, 8'hff, 8'hff));
		send_fragment(make_frag(16'h0100, 16'h8000, 8'hff, 8'hff, 8'hff, 8'h80));
		send_fragment(make_frag(16'h0100, 16'h1000, 8'hff, 8'hff, 8'hff, 8'hff));
		send_fragment(make_frag(16'h0100, 16'h0fff, 8'h00, 8'h7f, 8'hff, 8'h00));
	endtask

	// losing fragments take the double blend with the stored alpha
	task automatic test_depth_fail;
		send_fragment(make_frag(16'h0200, 16'hf000, 8'h12, 8'h34, 8'h56, 8'hc0));
		send_fragment(make_frag(16'h0200, 16'hefff, 8'hfe, 8'h01, 8'h80, 8'h40));
		send_fragment(make_frag(16'h0200, 16'hf000, 8'h00, 8'hff, 8'h33, 8'h01));
		send_fragment(make_frag(16'h0200, 16'h0000, 8'h9a, 8'hbc, 8'hde, 8'hfe));
		send_fragment(make_frag(16'h0200, 16'hffff, 8'h01, 8'h02, 8'h03, 8'h00));
		send_fragment(make_frag(16'h0200, 16'hfffe, 8'hff, 8'h00, 8'hff, 8'hff));
	endtask

	// back-to-back hits on one pixel, no idling on either side
	task automatic test_same_pixel_burst;
		quiet = 1'b1;
		send_fragment(make_frag(16'h0300, 16'h4000, 8'h10, 8'h20, 8'h30, 8'h80));
		send_fragment(make_frag(16'h0300, 16'h3fff, 8'h40, 8'h50, 8'h60, 8'h20));
		send_fragment(make_frag(16'h0300, 16'h4000, 8'hf0, 8'he0, 8'hd0, 8'hff));
		send_fragment(make_frag(16'h0301, 16'h0001, 8'h11, 8'h22, 8'h33, 8'h44));
		send_fragment(make_frag(16'h0300, 16'h7000, 8'h00, 8'h00, 8'h00, 8'h00));
		send_fragment(make_frag(16'h0300, 16'h6fff, 8'hff, 8'hff, 8'hff, 8'h7f));
		quiet = 1'b0;
	endtask

	// random stream: mostly a few hot pixels with depth near the stored one
	task automatic test_random_stream;
		logic [15:0] hot [16];
		logic [15:0] pix;
		logic [15:0] prev;
		logic [15:0] z;
		logic [7:0]  a;
		int unsigned pick;
		int          near;
		foreach (hot[i])
			hot[i] = 16'($urandom);
		prev = hot[0];
		for (int unsigned n = 0; n < RANDOM_FRAGS; n++) begin
			if (n % 64 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 15)
				pix = prev;
			else if (pick < 70)
				pix = hot[$urandom_range(0, 15)];
			else
				pix = 16'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				z = 16'($urandom);
			end else if (pick < 40) begin
				z = depth_mem[pix];
			end else begin
				near = int'(depth_mem[pix]) + $urandom_range(0, 600) - 300;
				z    = (near < 0) ? 16'h0000 : (near > 65535) ? 16'hffff : 16'(near);
			end
			pick = $urandom_range(0, 99);
			a    = (pick < 10) ? 8'h00 : (pick < 20) ? 8'hff : 8'($urandom);
			send_fragment(make_frag(pix, z, 8'($urandom), 8'($urandom), 8'($urandom), a));
			prev = pix;
		end
		quiet = 1'b0;
	endtask

	// main sequence
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_cleared_stores();
		test_saturation();
		test_depth_fail();
		test_same_pixel_burst();
		test_random_stream();
		frag_valid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d fragments and %0d result transfers with random gaps and stalls",
			frags_sent, results_seen);
		$display("depth test won %0d times and lost %0d times, %0d mismatches",
			depth_wins, depth_losses, error_count);
		if (error_count == 0)
			$display("depth_tested_alpha_blend_writer regression: pass");
		else
			$display("depth_tested_alpha_blend_writer regression: fail");
		$finish;
	end

	// stores start cleared, as after the clearing pass
	initial begin
		foreach (depth_mem[i])
			depth_mem[i] = '0;
		foreach (colour_mem[i])
			colour_mem[i] = '0;
	end

endmodule
